// ----- sv/rwf_pkg.sv -----
// rwf_pkg: shared types and constants for the rgb window filter
// no dependencies; imported by rwf_div, rgb_window_filter_generalized, rwf_checker and the testbench
`default_nettype none
package rwf_pkg;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int PADDR_W   = 5;
    localparam int TERM_W    = 25;
    localparam int CH_W      = 8;

    localparam logic [1:0] ACT_COEF  = 2'd0;
    localparam logic [1:0] ACT_PIXEL = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;
    localparam logic [1:0] ACT_BAD   = 2'd3;

    localparam logic [1:0] RED_SUM  = 2'd0;
    localparam logic [1:0] RED_MAX  = 2'd1;
    localparam logic [1:0] RED_MIN  = 2'd2;
    localparam logic [1:0] RED_MEAN = 2'd3;

    localparam logic [1:0] CMB_MUL = 2'd0;
    localparam logic [1:0] CMB_ADD = 2'd1;
    localparam logic [1:0] CMB_SUB = 2'd2;
    localparam logic [1:0] CMB_BAD = 2'd3;

    localparam logic [2:0] REG_KSIZE  = 3'd0;
    localparam logic [2:0] REG_ACOL   = 3'd1;
    localparam logic [2:0] REG_AROW   = 3'd2;
    localparam logic [2:0] REG_REDUCE = 3'd3;
    localparam logic [2:0] REG_COMB   = 3'd4;
    localparam logic [2:0] REG_CROSS  = 3'd5;
    localparam logic [2:0] REG_WIDTH  = 3'd6;
    localparam logic [2:0] REG_HEIGHT = 3'd7;

    typedef struct packed {
        logic busy;
        logic done;
    } rwf_div_stat_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DEC   = 7'b0000010,
        ST_TAP   = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_CALC  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } rwf_state_t;

endpackage
`default_nettype wire

// ----- sv/rwf_div.sv -----
// rwf_div: three-lane restoring divider, one quotient bit per cycle
// depends on rwf_pkg
`default_nettype none
module rwf_div #(
    parameter int AW  = 31,
    parameter int DVW = 14
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [2:0][AW-1:0]           dividend,
    input  wire logic [DVW-1:0]               divisor,
    output rwf_pkg::rwf_div_stat_t            stat,
    output logic      [2:0][rwf_pkg::CH_W-1:0] quot
);
    import rwf_pkg::*;

    localparam int CNW = $clog2(AW + 1);

    logic [2:0][AW-1:0] dvd_reg;
    logic [2:0][DVW:0]  rem_reg;
    logic [DVW-1:0]     dsr_reg;
    logic [CNW-1:0]     cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [2:0][DVW:0]  rem_sh;
    logic [2:0]         qbit;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rem_sh[i] = {rem_reg[i][DVW-1:0], dvd_reg[i][AW-1]};
            qbit[i]   = rem_sh[i] >= {1'b0, dsr_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(AW);
                dsr_reg  <= divisor;
                for (int i = 0; i < 3; i++) begin
                    dvd_reg[i] <= dividend[i];
                    rem_reg[i] <= '0;
                end
            end else if (busy_reg) begin
                for (int i = 0; i < 3; i++) begin
                    dvd_reg[i] <= {dvd_reg[i][AW-2:0], qbit[i]};
                    rem_reg[i] <= qbit[i] ? rem_sh[i] - {1'b0, dsr_reg} : rem_sh[i];
                end
                cnt_reg <= cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        stat.busy = busy_reg;
        stat.done = done_reg;
        for (int i = 0; i < 3; i++) begin
            quot[i] = dvd_reg[i][CH_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- sv/rgb_window_filter_generalized.sv -----
// rgb_window_filter_generalized: windowed rgb filter, one line-store read per kernel tap
// coefficient load, or pixel or flush without result: ST_IDLE then ST_DEC
// with a result: ST_IDLE, ST_DEC, ST_TAP per kernel tap, ST_DRAIN, ST_CALC, ST_DIV for mean, ST_FIN
// rate is set by the single read port of the line store, one tap per cycle
// reset: synchronous, clears positions and coefficient valid bits, restores config defaults; line store not cleared
`default_nettype none
module rgb_window_filter_generalized #(
    parameter int KMAX       = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // coef_index, coef_value, pix_red, pix_green, pix_blue, zero pad
    input  wire logic [rwf_pkg::S_TDATA_W-1:0]   s_tdata,
    // action
    input  wire logic [rwf_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_red, out_green, out_blue, out_col, out_row, zero pad
    output logic      [rwf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                 m_tlast,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rwf_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import rwf_pkg::*;

    localparam int KW     = $clog2(KMAX + 1);
    localparam int RMW    = $clog2(KMAX);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int XW     = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
    localparam int YW     = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;
    localparam int PW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int CDEPTH = KMAX * KMAX;
    localparam int CIW    = $clog2(CDEPTH);
    localparam int NW     = $clog2(CDEPTH + 1);
    localparam int AW     = TERM_W + NW;
    localparam int DVW    = NW + 8;
    localparam int LAW    = RMW + CW;
    localparam int LDEPTH = KMAX << CW;

    // configuration
    logic [2:0]  ksize_reg, acol_reg, arow_reg;
    logic [1:0]  rmode_reg, cmode_reg;
    logic        cross_reg;
    logic [10:0] iw_reg, ih_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    logic [KW-1:0]  k_s;
    logic [RMW-1:0] ac_s, ar_s;
    logic [XW-1:0]  w_s;
    logic [YW-1:0]  h_s;
    logic [PW-1:0]  total_reg, lag_reg;

    // positions
    logic [PW-1:0]  in_pos_reg, out_pos_reg;
    logic [CW-1:0]  in_col_reg, out_col_reg;
    logic [RMW-1:0] in_rm_reg, out_rm_reg;
    logic [RW-1:0]  out_row_reg;

    // item
    rwf_state_t      state_reg;
    logic [1:0]      act_reg;
    logic [5:0]      cidx_reg;
    logic [15:0]     cval_reg;
    logic [23:0]     pix_reg;

    // tap walk
    logic [RMW-1:0]       ta_reg, tb_reg, trm_reg;
    logic signed [YW:0]   ty_reg;
    logic signed [XW:0]   tx_reg, tx0_reg;
    logic [CIW-1:0]       tci_row_reg;
    logic                 use_q;
    logic                 tap_in, tap_keep, tap_last;
    logic [RMW:0]         trm_init;
    logic signed [XW:0]   tx_init;

    // memories
    logic [23:0]          lmem [LDEPTH];
    logic [23:0]          lmem_q;
    logic                 lwr_en;
    logic [LAW-1:0]       lw_addr, lr_addr;
    logic [15:0]          cmem [CDEPTH];
    logic [CDEPTH-1:0]    cvalid_reg;
    logic [15:0]          coef_q;
    logic                 cval_q;
    logic                 cwr_en;
    logic [CIW-1:0]       cr_addr;

    // accumulation
    logic signed [AW-1:0]     acc_reg  [3];
    logic signed [AW-1:0]     acc_next [3];
    logic signed [TERM_W-1:0] term_s   [3];
    logic [NW-1:0]            n_reg;
    logic signed [15:0]       cf_s;
    logic [2:0][CH_W-1:0]     res_reg;
    logic [2:0][CH_W-1:0]     res_calc;
    logic [2:0]               neg_reg;

    // divider
    logic                     div_start;
    logic [2:0][AW-1:0]       div_dvd;
    rwf_div_stat_t            div_stat;
    logic [2:0][CH_W-1:0]     div_q;

    // output
    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic                     m_tlast_reg;
    logic                     out_free, in_acc, emit_ok, frame_last;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksize_reg <= 3'd3;
            acol_reg  <= 3'd1;
            arow_reg  <= 3'd1;
            rmode_reg <= RED_SUM;
            cmode_reg <= CMB_MUL;
            cross_reg <= 1'b0;
            iw_reg    <= 11'd640;
            ih_reg    <= 11'd480;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KSIZE:  ksize_reg <= pwdata[2:0];
                REG_ACOL:   acol_reg  <= pwdata[2:0];
                REG_AROW:   arow_reg  <= pwdata[2:0];
                REG_REDUCE: rmode_reg <= pwdata[1:0];
                REG_COMB:   cmode_reg <= pwdata[1:0];
                REG_CROSS:  cross_reg <= pwdata[0];
                REG_WIDTH:  iw_reg    <= pwdata[10:0];
                REG_HEIGHT: ih_reg    <= pwdata[10:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_KSIZE:  prdata = {29'd0, ksize_reg};
            REG_ACOL:   prdata = {29'd0, acol_reg};
            REG_AROW:   prdata = {29'd0, arow_reg};
            REG_REDUCE: prdata = {30'd0, rmode_reg};
            REG_COMB:   prdata = {30'd0, cmode_reg};
            REG_CROSS:  prdata = {31'd0, cross_reg};
            REG_WIDTH:  prdata = {21'd0, iw_reg};
            REG_HEIGHT: prdata = {21'd0, ih_reg};
            default:    prdata = '0;
        endcase
    end

    // saturated settings
    always_comb begin
        if (ksize_reg == '0) k_s = KW'(1);
        else if (int'(ksize_reg) > KMAX) k_s = KW'(KMAX);
        else k_s = KW'(ksize_reg);
        if (int'(acol_reg) > int'(k_s) - 1) ac_s = RMW'(int'(k_s) - 1);
        else ac_s = RMW'(acol_reg);
        if (int'(arow_reg) > int'(k_s) - 1) ar_s = RMW'(int'(k_s) - 1);
        else ar_s = RMW'(arow_reg);
        if (iw_reg == '0) w_s = XW'(1);
        else if (int'(iw_reg) > MAX_WIDTH) w_s = XW'(MAX_WIDTH);
        else w_s = XW'(iw_reg);
        if (ih_reg == '0) h_s = YW'(1);
        else if (int'(ih_reg) > MAX_HEIGHT) h_s = YW'(MAX_HEIGHT);
        else h_s = YW'(ih_reg);
    end

    always_ff @(posedge aclk) begin
        total_reg <= PW'(int'(w_s) * int'(h_s));
        lag_reg   <= PW'((int'(k_s) - int'(ar_s) - 1) * int'(w_s)
                         + int'(k_s) - int'(ac_s) - 1);
    end

    // tap window decode
    always_comb begin
        tap_in   = (ty_reg >= 0) && (ty_reg < $signed({1'b0, h_s}))
                && (tx_reg >= 0) && (tx_reg < $signed({1'b0, w_s}));
        tap_keep = !cross_reg
                || (ta_reg == RMW'(1) && (tb_reg == RMW'(0) || tb_reg == RMW'(2)))
                || (tb_reg == RMW'(1) && (ta_reg == RMW'(0) || ta_reg == RMW'(2)));
        tap_last = (KW'(ta_reg) == k_s - KW'(1)) && (KW'(tb_reg) == k_s - KW'(1));
        lr_addr  = {trm_reg, tx_reg[CW-1:0]};
        cr_addr  = tci_row_reg + CIW'(tb_reg);
        trm_init = {1'b0, out_rm_reg} + (RMW+1)'(KMAX) - {1'b0, ar_s};
        if (trm_init >= (RMW+1)'(KMAX)) trm_init = trm_init - (RMW+1)'(KMAX);
        tx_init  = $signed({1'b0, XW'(out_col_reg)}) - $signed((XW+1)'(ac_s));
    end

    // line and coefficient stores
    assign lwr_en  = (state_reg == ST_DEC) && (act_reg == ACT_PIXEL) && (in_pos_reg < total_reg);
    assign lw_addr = {in_rm_reg, in_col_reg};
    assign cwr_en  = (state_reg == ST_DEC) && (act_reg == ACT_COEF) && (int'(cidx_reg) < CDEPTH);

    always_ff @(posedge aclk) begin
        if (lwr_en) begin
            lmem[lw_addr] <= pix_reg;
        end
        lmem_q <= lmem[lr_addr];
    end

    always_ff @(posedge aclk) begin
        if (cwr_en) begin
            cmem[CIW'(cidx_reg)] <= cval_reg;
        end
        coef_q <= cmem[cr_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvalid_reg <= '0;
            cval_q     <= 1'b0;
        end else begin
            if (cwr_en) begin
                cvalid_reg[CIW'(cidx_reg)] <= 1'b1;
            end
            cval_q <= cvalid_reg[cr_addr];
        end
    end

    // per-channel term and reduction
    always_comb begin
        cf_s = cval_q ? $signed(coef_q) : 16'sd0;
        for (int ch = 0; ch < 3; ch++) begin
            case (cmode_reg)
                CMB_MUL: term_s[ch] = $signed(TERM_W'({1'b0, lmem_q[23-8*ch -: 8]}))
                                    * $signed(TERM_W'(cf_s));
                CMB_ADD: term_s[ch] = $signed(TERM_W'({lmem_q[23-8*ch -: 8], 8'h00}))
                                    + $signed(TERM_W'(cf_s));
                default: term_s[ch] = $signed(TERM_W'({lmem_q[23-8*ch -: 8], 8'h00}))
                                    - $signed(TERM_W'(cf_s));
            endcase
            case (rmode_reg)
                RED_MAX: acc_next[ch] = (n_reg == '0 || AW'(term_s[ch]) > acc_reg[ch])
                                      ? AW'(term_s[ch]) : acc_reg[ch];
                RED_MIN: acc_next[ch] = (n_reg == '0 || AW'(term_s[ch]) < acc_reg[ch])
                                      ? AW'(term_s[ch]) : acc_reg[ch];
                default: acc_next[ch] = acc_reg[ch] + AW'(term_s[ch]);
            endcase
            res_calc[ch] = acc_reg[ch][AW-1] ? CH_W'((acc_reg[ch] + AW'(255)) >>> 8)
                                             : CH_W'(acc_reg[ch] >>> 8);
            div_dvd[ch]  = acc_reg[ch][AW-1] ? AW'(-acc_reg[ch]) : AW'(acc_reg[ch]);
        end
    end

    assign div_start = (state_reg == ST_CALC) && (rmode_reg == RED_MEAN) && (n_reg != '0);

    rwf_div #(
        .AW  (AW),
        .DVW (DVW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  ({n_reg, 8'h00}),
        .stat     (div_stat),
        .quot     (div_q)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign emit_ok    = ({1'b0, in_pos_reg} >= ({1'b0, out_pos_reg} + {1'b0, lag_reg}))
                     && (out_pos_reg < total_reg);
    assign frame_last = ({1'b0, out_pos_reg} + (PW+1)'(1)) >= {1'b0, total_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_pos_reg   <= '0;
            in_col_reg   <= '0;
            in_rm_reg    <= '0;
            out_pos_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_rm_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            use_q        <= 1'b0;
        end else begin
            use_q <= (state_reg == ST_TAP) && tap_in && tap_keep;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (use_q) begin
                for (int ch = 0; ch < 3; ch++) acc_reg[ch] <= acc_next[ch];
                n_reg <= n_reg + NW'(1);
            end
            if (cfg_wr) begin
                in_pos_reg  <= '0;
                in_col_reg  <= '0;
                in_rm_reg   <= '0;
                out_pos_reg <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                out_rm_reg  <= '0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        act_reg   <= s_tuser;
                        cidx_reg  <= s_tdata[5:0];
                        cval_reg  <= s_tdata[21:6];
                        pix_reg   <= {s_tdata[29:22], s_tdata[37:30], s_tdata[45:38]};
                        state_reg <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    state_reg <= ST_IDLE;
                    if ((act_reg == ACT_PIXEL && in_pos_reg < total_reg && emit_ok)
                        || (act_reg == ACT_FLUSH && out_pos_reg < total_reg)) begin
                        state_reg   <= ST_TAP;
                        ta_reg      <= '0;
                        tb_reg      <= '0;
                        trm_reg     <= RMW'(trm_init);
                        ty_reg      <= $signed({1'b0, YW'(out_row_reg)})
                                     - $signed((YW+1)'(ar_s));
                        tx_reg      <= tx_init;
                        tx0_reg     <= tx_init;
                        tci_row_reg <= '0;
                        n_reg       <= '0;
                        for (int ch = 0; ch < 3; ch++) acc_reg[ch] <= '0;
                    end
                    if (lwr_en) begin
                        in_pos_reg <= in_pos_reg + PW'(1);
                        if (XW'(in_col_reg) == w_s - XW'(1)) begin
                            in_col_reg <= '0;
                            in_rm_reg  <= (in_rm_reg == RMW'(KMAX - 1)) ? '0
                                        : in_rm_reg + RMW'(1);
                        end else begin
                            in_col_reg <= in_col_reg + CW'(1);
                        end
                    end
                end
                ST_TAP: begin
                    if (tap_last) begin
                        state_reg <= ST_DRAIN;
                    end else if (KW'(tb_reg) == k_s - KW'(1)) begin
                        tb_reg      <= '0;
                        tx_reg      <= tx0_reg;
                        ta_reg      <= ta_reg + RMW'(1);
                        ty_reg      <= ty_reg + (YW+1)'(1);
                        trm_reg     <= (trm_reg == RMW'(KMAX - 1)) ? '0 : trm_reg + RMW'(1);
                        tci_row_reg <= tci_row_reg + CIW'(KMAX);
                    end else begin
                        tb_reg <= tb_reg + RMW'(1);
                        tx_reg <= tx_reg + (XW+1)'(1);
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_CALC;
                end
                ST_CALC: begin
                    for (int ch = 0; ch < 3; ch++) neg_reg[ch] <= acc_reg[ch][AW-1];
                    if (rmode_reg == RED_MEAN) begin
                        res_reg <= '0;
                        state_reg <= (n_reg != '0) ? ST_DIV : ST_FIN;
                    end else begin
                        res_reg   <= res_calc;
                        state_reg <= ST_FIN;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        for (int ch = 0; ch < 3; ch++) begin
                            res_reg[ch] <= neg_reg[ch] ? CH_W'(~div_q[ch] + CH_W'(1))
                                                       : div_q[ch];
                        end
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, 10'(out_row_reg), 10'(out_col_reg),
                                         res_reg[2], res_reg[1], res_reg[0]};
                        m_tlast_reg  <= frame_last;
                        state_reg    <= ST_IDLE;
                        if (frame_last) begin
                            in_pos_reg  <= '0;
                            in_col_reg  <= '0;
                            in_rm_reg   <= '0;
                            out_pos_reg <= '0;
                            out_col_reg <= '0;
                            out_row_reg <= '0;
                            out_rm_reg  <= '0;
                        end else begin
                            out_pos_reg <= out_pos_reg + PW'(1);
                            if (XW'(out_col_reg) == w_s - XW'(1)) begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + RW'(1);
                                out_rm_reg  <= (out_rm_reg == RMW'(KMAX - 1)) ? '0
                                             : out_rm_reg + RMW'(1);
                            end else begin
                                out_col_reg <= out_col_reg + CW'(1);
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_div_mean_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rmode_reg == RED_MEAN))
        else $error("divider busy outside mean mode");

    a_coef_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEC && act_reg == ACT_COEF) |=> (state_reg == ST_IDLE))
        else $error("coefficient beat started a window walk");

    a_tap_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAP) |-> (out_pos_reg < total_reg))
        else $error("window walk past end of frame");

endmodule
`default_nettype wire

// ----- verif/rwf_checker.sv -----
// rwf_checker: watches the apb port and both streams of the rgb window filter,
// predicts each output pixel and compares it; depends on rwf_pkg
`default_nettype none
module rwf_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic        m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fails,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rwf_pkg::*;

    localparam int KM = 7;
    localparam int MW = 1024;

    typedef struct {
        logic [7:0] red, green, blue;
        logic [9:0] col, row;
        logic       last;
    } pix_out_t;

    logic [23:0]        line_mem [0:KM*MW-1];
    logic signed [15:0] coef_mem [0:KM*KM-1];
    int                 col_in, row_in, out_pos;
    logic [2:0]         ksz, acol, arow;
    logic [1:0]         red_mode, cmb_mode;
    logic               cross_md;
    logic [10:0]        wreg, hreg;
    pix_out_t           expected_q[$];

    function automatic int eff_side();
        return ksz < 1 ? 1 : (ksz > KM ? KM : int'(ksz));
    endfunction

    function automatic int eff_anchor(logic [2:0] a);
        return a > eff_side() - 1 ? eff_side() - 1 : int'(a);
    endfunction

    function automatic int eff_w();
        return wreg < 1 ? 1 : (wreg > MW ? MW : int'(wreg));
    endfunction

    function automatic int eff_h();
        return hreg < 1 ? 1 : (hreg > 1024 ? 1024 : int'(hreg));
    endfunction

    function automatic void filter_pixel();
        int w, h, k, total, r, c, ar, ac, yy, xx;
        longint acc[3], n, p, t, cf, v;
        logic [23:0] px;
        bit keep;
        pix_out_t o;
        w = eff_w(); h = eff_h(); k = eff_side(); total = w * h;
        r = out_pos / w; c = out_pos % w;
        ar = eff_anchor(arow); ac = eff_anchor(acol);
        acc = '{0, 0, 0}; n = 0;
        for (int a = 0; a < k; a++) begin
            yy = r - ar + a;
            if (yy < 0 || yy >= h) continue;
            for (int b = 0; b < k; b++) begin
                xx = c - ac + b;
                if (xx < 0 || xx >= w) continue;
                keep = !cross_md || (a == 1 && (b == 0 || b == 2))
                    || (b == 1 && (a == 0 || a == 2));
                if (!keep) continue;
                px = line_mem[(yy % KM) * MW + xx];
                cf = coef_mem[a * KM + b];
                for (int ch = 0; ch < 3; ch++) begin
                    p = (px >> (16 - 8 * ch)) & 8'hFF;
                    if (cmb_mode == CMB_MUL) t = p * cf;
                    else if (cmb_mode == CMB_ADD) t = p * 256 + cf;
                    else t = p * 256 - cf;
                    if (red_mode == RED_MAX) acc[ch] = (n == 0 || t > acc[ch]) ? t : acc[ch];
                    else if (red_mode == RED_MIN) acc[ch] = (n == 0 || t < acc[ch]) ? t : acc[ch];
                    else acc[ch] += t;
                end
                n++;
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            if (red_mode == RED_MEAN) v = n == 0 ? 0 : acc[ch] / (256 * n);
            else v = acc[ch] / 256;
            acc[ch] = v & 8'hFF;
        end
        o.red = acc[0][7:0]; o.green = acc[1][7:0]; o.blue = acc[2][7:0];
        o.col = c[9:0]; o.row = r[9:0];
        out_pos++;
        o.last = out_pos >= total;
        if (o.last) begin
            col_in = 0; row_in = 0; out_pos = 0;
        end
        expected_q.push_back(o);
    endfunction

    function automatic void cmp(string nm, int e, int g);
        if (e != g) begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, nm, e, g);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        int w, total, received, lag;
        logic [5:0] idx;
        pix_out_t e;
        if (!aresetn) begin
            foreach (coef_mem[i]) coef_mem[i] = '0;
            col_in = 0; row_in = 0; out_pos = 0;
            ksz = 3; acol = 1; arow = 1; red_mode = RED_SUM; cmb_mode = CMB_MUL;
            cross_md = 0; wreg = 640; hreg = 480;
            expected_q.delete();
            fails = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected beat actual %h last %b", $time, m_tdata, m_tlast);
                    fails++;
                end else begin
                    e = expected_q.pop_front();
                    cmp("out_red", e.red, m_tdata[7:0]);
                    cmp("out_green", e.green, m_tdata[15:8]);
                    cmp("out_blue", e.blue, m_tdata[23:16]);
                    cmp("out_col", e.col, m_tdata[33:24]);
                    cmp("out_row", e.row, m_tdata[43:34]);
                    cmp("frame_end", e.last, m_tlast);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_KSIZE:  ksz = pwdata[2:0];
                    REG_ACOL:   acol = pwdata[2:0];
                    REG_AROW:   arow = pwdata[2:0];
                    REG_REDUCE: red_mode = pwdata[1:0];
                    REG_COMB:   cmb_mode = pwdata[1:0];
                    REG_CROSS:  cross_md = pwdata[0];
                    REG_WIDTH:  wreg = pwdata[10:0];
                    REG_HEIGHT: hreg = pwdata[10:0];
                    default: ;
                endcase
                col_in = 0; row_in = 0; out_pos = 0;
            end
            if (s_tvalid && s_tready) begin
                w = eff_w(); total = w * eff_h();
                lag = (eff_side() - 1 - eff_anchor(arow)) * w + (eff_side() - 1 - eff_anchor(acol));
                idx = s_tdata[5:0];
                case (s_tuser)
                    ACT_COEF: if (idx < KM * KM) coef_mem[idx] = s_tdata[21:6];
                    ACT_PIXEL: begin
                        received = row_in * w + col_in;
                        if (received < total) begin
                            line_mem[(row_in % KM) * MW + col_in] =
                                {s_tdata[29:22], s_tdata[37:30], s_tdata[45:38]};
                            col_in++;
                            if (col_in >= w) begin
                                col_in = 0;
                                row_in++;
                            end
                            if (out_pos < total && received >= out_pos + lag) filter_pixel();
                        end
                    end
                    ACT_FLUSH: if (out_pos < total) filter_pixel();
                    default: ;
                endcase
            end
        end
        pending = expected_q.size();
    end
endmodule
`default_nettype wire

// ----- verif/tb_rgb_window_filter_generalized.sv -----
// tb_rgb_window_filter_generalized: stimulus and verdict for the rgb window filter
// depends on rwf_pkg, rgb_window_filter_generalized and rwf_checker
`default_nettype none
module tb_rgb_window_filter_generalized;
    timeunit 1ns;
    timeprecision 1ps;
    import rwf_pkg::*;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
    logic [47:0] s_tdata, m_tdata;
    logic [1:0]  s_tuser;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fails, pending, cycles, sent;
    bit          hold_req, no_gaps;
    int          cur_w, cur_h, cur_lag;

    rgb_window_filter_generalized dut (.*);

    rwf_checker chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready,
        .m_tdata, .m_tlast, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .fails, .pending
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 2000000) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side backpressure
    initial begin
        int n;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end else if (!no_gaps && $urandom_range(0, 49) == 0) begin
                m_tready <= 0;
                n = $urandom_range(10, 60);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= no_gaps || $urandom_range(0, 3) != 0;
            end
        end
    end

    task automatic send(logic [1:0] act, logic [5:0] idx);
        int gap;
        gap = no_gaps ? 0 : ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40)
                                                        : $urandom_range(0, 2));
        repeat (gap) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= act;
        s_tdata <= {2'b0, 24'($urandom), 16'($urandom), idx};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic idle_wait();
        s_tvalid <= 0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] r, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0;
    endtask

    task automatic setup(int k, int ac, int ar, logic [1:0] rm, logic [1:0] cm, bit cr,
                         int w, int h);
        int ks, acs, ars;
        idle_wait();
        apb_write(REG_KSIZE, k); apb_write(REG_ACOL, ac); apb_write(REG_AROW, ar);
        apb_write(REG_REDUCE, rm); apb_write(REG_COMB, cm); apb_write(REG_CROSS, cr);
        apb_write(REG_WIDTH, w); apb_write(REG_HEIGHT, h);
        ks = k < 1 ? 1 : k;
        acs = ac > ks - 1 ? ks - 1 : ac;
        ars = ar > ks - 1 ? ks - 1 : ar;
        cur_w = w < 1 ? 1 : (w > 1024 ? 1024 : w);
        cur_h = h < 1 ? 1 : (h > 1024 ? 1024 : h);
        cur_lag = (ks - 1 - ars) * cur_w + (ks - 1 - acs);
    endtask

    // noise only on narrow frames, whose store rows were all filled up front
    task automatic frame(bit noisy);
        int total, r;
        total = cur_w * cur_h;
        for (int i = 0; i < total; i++) begin
            r = $urandom_range(0, 19);
            if (noisy && r == 0) send(ACT_FLUSH, 6'($urandom));
            else if (noisy && r == 1) send(ACT_BAD, 6'($urandom));
            else if (noisy && r == 2) send(ACT_COEF, 6'($urandom));
            send(ACT_PIXEL, 6'($urandom));
        end
        if (noisy) repeat ($urandom_range(0, 2)) send(ACT_PIXEL, 6'($urandom));
        repeat (cur_lag < total ? cur_lag : total) send(ACT_FLUSH, 6'($urandom));
    endtask

    initial begin
        int ph;
        aresetn = 0; s_tvalid = 0; s_tdata = '0; s_tuser = ACT_COEF;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        hold_req = 0; no_gaps = 0; sent = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        setup(3, 1, 1, RED_SUM, CMB_MUL, 0, 16, 8);
        for (int i = 0; i < 9; i++) send(ACT_COEF, 6'((i / 3) * 7 + i % 3));
        send(ACT_COEF, 6'd48);
        send(ACT_COEF, 6'd49);
        send(ACT_COEF, 6'd63);
        send(ACT_BAD, 6'd0);
        frame(0);
        no_gaps = 1;
        setup(3, 1, 1, RED_MAX, CMB_ADD, 1, 16, 8);
        frame(0);
        no_gaps = 0;
        setup(3, 1, 1, RED_MIN, CMB_BAD, 0, 4, 3);
        send(ACT_FLUSH, 6'd0);
        send(ACT_FLUSH, 6'd0);
        frame(1);
        setup(0, 7, 7, RED_MEAN, CMB_MUL, 0, 0, 0);
        frame(1);
        setup(7, 0, 0, RED_MEAN, CMB_SUB, 1, 3, 8);
        frame(1);
        // oversized width and height, partial frames only
        setup(7, 3, 6, RED_SUM, CMB_MUL, 0, 2047, 1);
        repeat (48) send(ACT_PIXEL, 6'($urandom));
        repeat (4) send(ACT_FLUSH, 6'($urandom));
        setup(1, 0, 0, RED_MAX, CMB_ADD, 0, 1, 2047);
        repeat (40) send(ACT_PIXEL, 6'($urandom));
        ph = 0;
        while (sent < 750 || ph < 3) begin
            setup($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                  2'($urandom), 2'($urandom), 1'($urandom), $urandom_range(0, 16),
                  $urandom_range(0, 8));
            repeat ($urandom_range(0, 10)) send(ACT_COEF, 6'($urandom_range(0, 63)));
            no_gaps = $urandom_range(0, 4) == 0;
            if (ph == 1) hold_req = 1;
            if (ph == 2) begin
                frame(0);
                s_tvalid <= 0;
                repeat (2) @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            repeat ($urandom_range(1, 3)) frame($urandom_range(0, 2) == 0);
            ph++;
        end
        idle_wait();
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
sv/rwf_pkg.sv
sv/rwf_div.sv
sv/rgb_window_filter_generalized.sv
verif/rwf_checker.sv
verif/tb_rgb_window_filter_generalized.sv
